/* src/stq_pkg.sv */
// Shared types and constants for the sorted timer expiry queue.
package stq_pkg;

  localparam int TICK_W  = 64;
  localparam int ID_W    = 4;
  localparam int FUNC_W  = 2;
  localparam int PEND_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MARK_HEAD,
    OP_MARK_ID,
    OP_SHIFT,
    OP_INSERT
  } stq_op_t;

  typedef struct packed {
    stq_op_t            op;
    logic [ID_W-1:0]    id;
    logic [TICK_W-1:0]  expiry;
  } stq_ctrl_t;

  // One queue slot as seen by the neighbors.
  typedef struct packed {
    logic               valid;
    logic [TICK_W-1:0]  expiry;
    logic [ID_W-1:0]    owner;
  } stq_entry_t;

endpackage

/* src/stq_cell.sv */
// One slot of the sorted timer chain: holds an entry and trades it with its neighbors.
module stq_cell (
  input  logic             clk,
  input  logic             rst,
  input  stq_pkg::stq_ctrl_t  ctrl,
  input  logic             head_fire,
  input  stq_pkg::stq_entry_t left_entry,
  input  logic             left_gt,
  input  logic             left_hole,
  input  stq_pkg::stq_entry_t right_entry,
  output stq_pkg::stq_entry_t entry,
  output logic             gt,
  output logic             hole,
  output logic             match
);
  import stq_pkg::*;

  logic              valid;
  logic [TICK_W-1:0] expiry;
  logic [ID_W-1:0]   owner;

  assign entry = '{valid: valid, expiry: expiry, owner: owner};
  assign match = valid && (owner == ctrl.id);
  // empty slots count as later than anything, so the flag stays monotone
  assign gt    = !valid || (expiry > ctrl.expiry);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hole  <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_MARK_HEAD: hole <= head_fire;
        OP_MARK_ID:   hole <= match;
        OP_SHIFT: begin
          if (hole) valid <= right_entry.valid;
          // hole moves right only while there is something to pull in
          hole <= left_hole && valid;
        end
        OP_INSERT: begin
          if (left_gt) valid <= left_entry.valid;
          else if (gt) valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_SHIFT: begin
        if (hole) begin
          expiry <= right_entry.expiry;
          owner  <= right_entry.owner;
        end
      end
      OP_INSERT: begin
        if (left_gt) begin
          expiry <= left_entry.expiry;
          owner  <= left_entry.owner;
        end else if (gt) begin
          expiry <= ctrl.expiry;
          owner  <= ctrl.id;
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/sorted_timer_expiry_queue.sv */
// Top level of the sorted timer expiry queue: control sequencer over a chain of slot cells.
//
//  Channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  in      | in_valid  | in_stall  | func, timer_id, expires
//  out     | out_valid | out_stall | fired, fired_id, now_tick, pending_count
//
// Steps per transaction, from the accepting edge to the result load: a tick that fires, or
// a delete, marks its slot and walks the gap toward the tail, one cell per cycle (S_REMOVE);
// an add does the same for a pending entry of its id, then inserts (S_INSERT); all end in
// S_DONE, which loads the result. A tick without expiry or an unused code goes to S_DONE.
// Reset clears the tick count, all slot valid flags and the sequencer; slot payload
// is not cleared. A new transaction is taken whenever the sequencer is idle, even
// while the previous result is still held by out_stall; the sequencer waits in its
// final step only while the output register is full and out_stall is held.
module sorted_timer_expiry_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [stq_pkg::FUNC_W-1:0]     func,
  input  logic [stq_pkg::ID_W-1:0]       timer_id,
  input  logic [stq_pkg::TICK_W-1:0]     expires,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           fired,
  output logic [stq_pkg::ID_W-1:0]       fired_id,
  output logic [stq_pkg::TICK_W-1:0]     now_tick,
  output logic [stq_pkg::PEND_W-1:0]     pending_count
);
  import stq_pkg::*;

  // Internal count holds 0..NUM_TIMERS; the port shows its low bits.
  localparam int CNT_W = ($clog2(NUM_TIMERS + 1) > PEND_W) ?
                         $clog2(NUM_TIMERS + 1) : PEND_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_DONE
  } state_t;

  state_t            state;
  logic [TICK_W-1:0] tick;
  logic [CNT_W-1:0]  count;
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   id_q;
  logic [TICK_W-1:0] exp_q;
  logic              fire_q;
  logic [ID_W-1:0]   fire_id_q;

  stq_ctrl_t         ctrl;
  stq_entry_t        ent     [NUM_TIMERS];
  logic              gt_v    [NUM_TIMERS];
  logic              hole_v  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] hole_bits;
  logic [NUM_TIMERS-1:0] match_bits;

  logic              in_accept;
  logic [TICK_W-1:0] tick_inc;
  logic              head_fire;
  logic              any_hole;
  logic              any_match;
  logic              chain_full;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign tick_inc   = tick + TICK_W'(1);
  // Head is the earliest timer; it fires once the incremented count reaches it.
  assign head_fire  = ent[0].valid && (ent[0].expiry <= tick_inc);
  assign any_hole   = |hole_bits;
  // Ids are unique in the queue, so at most one cell matches.
  assign any_match  = |match_bits;
  assign chain_full = ent[NUM_TIMERS-1].valid;

  // Command broadcast to the chain.
  always_comb begin
    ctrl.op     = OP_NONE;
    ctrl.id     = (state == S_IDLE) ? timer_id : id_q;
    ctrl.expiry = exp_q;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (func)
            FUNC_TICK:          ctrl.op = OP_MARK_HEAD;
            FUNC_ADD, FUNC_DEL: ctrl.op = OP_MARK_ID;
            default:            ctrl.op = OP_NONE;
          endcase
        end
      end
      S_REMOVE: ctrl.op = OP_SHIFT;
      S_INSERT: ctrl.op = chain_full ? OP_NONE : OP_INSERT;
      default:  ctrl.op = OP_NONE;
    endcase
  end

  // Chain of slot cells; slot 0 is the head.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    stq_entry_t left_e;
    stq_entry_t right_e;
    logic       left_g;
    logic       left_h;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
      assign left_h = 1'b0;
    end else begin : g_mid
      assign left_e = ent[i-1];
      assign left_g = gt_v[i-1];
      assign left_h = hole_v[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ent[i+1];
    end

    stq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .head_fire   ((i == 0) ? head_fire : 1'b0),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .left_hole   (left_h),
      .right_entry (right_e),
      .entry       (ent[i]),
      .gt          (gt_v[i]),
      .hole        (hole_v[i]),
      .match       (match_bits[i])
    );

    assign hole_bits[i] = hole_v[i];
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tick      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE the result load below owns out_valid
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            func_q    <= func;
            id_q      <= timer_id;
            exp_q     <= expires;
            fire_q    <= 1'b0;
            fire_id_q <= '0;
            case (func)
              FUNC_TICK: begin
                tick <= tick_inc;
                if (head_fire) begin
                  fire_q    <= 1'b1;
                  fire_id_q <= ent[0].owner;
                  count     <= count - CNT_W'(1);
                  state     <= S_REMOVE;
                end else begin
                  state <= S_DONE;
                end
              end
              FUNC_ADD, FUNC_DEL: begin
                if (any_match) count <= count - CNT_W'(1);
                state <= S_REMOVE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // gap walks toward the tail until it runs off the valid prefix
        S_REMOVE: begin
          if (!any_hole) state <= (func_q == FUNC_ADD) ? S_INSERT : S_DONE;
        end

        S_INSERT: begin
          if (!chain_full) count <= count + CNT_W'(1);
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            fired         <= fire_q;
            fired_id      <= fire_id_q;
            now_tick      <= tick;
            pending_count <= count[PEND_W-1:0];
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
